// ===== hw/rtl/ipf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared types and constants of the image post filter.
// ----------------------------------------------------------------------------
package ipf_pkg;

    localparam int FW_BITS = 12;
    localparam int FH_BITS = 13;
    localparam int CMP_W   = 14;
    localparam int PX_W    = 24;

    localparam logic [1:0] EMIT_NONE   = 2'd0;
    localparam logic [1:0] EMIT_DIRECT = 2'd1;
    localparam logic [1:0] EMIT_SMOOTH = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_AA     = 2'd2;
    localparam logic [1:0] REG_SEPIA  = 2'd3;

    localparam logic [8:0] SEPIA_R_OFS = 9'd112;
    localparam logic [8:0] SEPIA_G_OFS = 9'd66;
    localparam logic [8:0] SEPIA_B_OFS = 9'd20;

    localparam logic [3:0] CENTRE_WT = 4'd5;

    // Control word passed from the front end to the back end with each request.
    typedef struct packed {
        logic       is_pixel;
        logic       sepia;
        logic [1:0] emit;
        logic       frame_end;
        logic [7:0] nb_mask;
        logic [3:0] weight;
    } ipf_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/image_post_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// image_post_filter_core
// Weighted 3x3 smoothing, sepia tint or pass-through on a raster pixel stream.
// ----------------------------------------------------------------------------
// The back end takes each request through its states in order: row-store read,
// window load (with the row-store update for a pixel), then output; a smoothed
// one has a sum and eight divide steps between window load and output, and one
// that needs no output ends after the window load. It takes a new request only
// once the last is done, and holds the output state while out_stall is high.
// Reset: asynchronous, active low; positions, pending count, window and queue
// clear at once, registers return to 640 x 480 with both filters off.
module image_post_filter_core
    import ipf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [3:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic [7:0]                    red_in,
    input  wire logic [7:0]                    green_in,
    input  wire logic [7:0]                    blue_in,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [$clog2(MAX_WIDTH)-1:0]       col_out,
    output logic [$clog2(MAX_HEIGHT)-1:0]      row_out,
    output logic [7:0]                         red_out,
    output logic [7:0]                         green_out,
    output logic [7:0]                         blue_out,
    output logic                               frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int Q_W   = $bits(ipf_ctrl_t) + COL_W + PX_W + COL_W + ROW_W;

    // Configuration registers: user writes via APB only while idle, unchecked.
    logic [FW_BITS-1:0] frame_width_reg;
    logic [FH_BITS-1:0] frame_height_reg;
    logic               aa_enable_reg;
    logic               sepia_enable_reg;
    logic               cfg_write;

    // Request queue between the front end and the back end.
    logic             cmd_push, cmd_full, q_valid, q_pop;
    ipf_ctrl_t        cmd_ctrl, q_ctrl;
    logic [COL_W-1:0] cmd_addr, cmd_col, q_addr, q_col;
    logic [ROW_W-1:0] cmd_row, q_row;
    logic [PX_W-1:0]  cmd_px, q_px;
    logic [Q_W-1:0]   q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_BITS'(640);
            frame_height_reg <= FH_BITS'(480);
            aa_enable_reg    <= 1'b0;
            sepia_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  frame_width_reg  <= pwdata[FW_BITS-1:0];
                REG_HEIGHT: frame_height_reg <= pwdata[FH_BITS-1:0];
                REG_AA:     aa_enable_reg    <= pwdata[0];
                REG_SEPIA:  sepia_enable_reg <= pwdata[0];
                default:    aa_enable_reg    <= aa_enable_reg;
            endcase
        end
    end

    // Read-back of the register selected by the address.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(frame_width_reg);
            REG_HEIGHT: prdata = 32'(frame_height_reg);
            REG_AA:     prdata = 32'(aa_enable_reg);
            REG_SEPIA:  prdata = 32'(sepia_enable_reg);
            default:    prdata = '0;
        endcase
    end

    // The front end tracks positions and the pending count and decides, per
    // request, whether a result is due and of which kind.
    ipf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .aa_enable    (aa_enable_reg),
        .sepia_enable (sepia_enable_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .cmd_full     (cmd_full),
        .cmd_push     (cmd_push),
        .cmd_ctrl     (cmd_ctrl),
        .cmd_addr     (cmd_addr),
        .cmd_px       (cmd_px),
        .cmd_col      (cmd_col),
        .cmd_row      (cmd_row)
    );

    ipf_queue #(.WIDTH(Q_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data ({cmd_ctrl, cmd_addr, cmd_px, cmd_col, cmd_row}),
        .full      (cmd_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    assign {q_ctrl, q_addr, q_px, q_col, q_row} = q_head;

    // The back end owns the two row stores and the window, computes the mean
    // with a serial divider and holds the result until it is taken.
    ipf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_ctrl    (q_ctrl),
        .q_addr    (q_addr),
        .q_px      (q_px),
        .q_col     (q_col),
        .q_row     (q_row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .col_out   (col_out),
        .row_out   (row_out),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/ipf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ipf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ipf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipf_queue
// Two-entry queue decoupling the front end from the back end.
// ----------------------------------------------------------------------------
module ipf_queue #(
    parameter int WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head
);

    logic [WIDTH-1:0] slot_reg [2];
    logic [1:0]       count_reg, count_next;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ipf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipf_front
// Accepts requests, tracks input and output positions and classifies work.
// ----------------------------------------------------------------------------
module ipf_front
    import ipf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [FW_BITS-1:0]            frame_width,
    input  wire logic [FH_BITS-1:0]            frame_height,
    input  wire logic                          aa_enable,
    input  wire logic                          sepia_enable,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic [7:0]                    red_in,
    input  wire logic [7:0]                    green_in,
    input  wire logic [7:0]                    blue_in,
    input  wire logic                          cmd_full,
    output logic                               cmd_push,
    output ipf_ctrl_t                          cmd_ctrl,
    output logic [$clog2(MAX_WIDTH)-1:0]       cmd_addr,
    output logic [PX_W-1:0]                    cmd_px,
    output logic [$clog2(MAX_WIDTH)-1:0]       cmd_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]      cmd_row
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CWE   = COL_W + 1;
    localparam int RWE   = ROW_W + 1;
    localparam int PW    = COL_W + 2;

    logic [COL_W-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [PW-1:0]    pending_reg, pending_next;

    logic [CWE-1:0] eff_w, in_col_inc, out_col_inc, oc_x;
    logic [RWE-1:0] eff_h, in_row_inc, out_row_inc, or_x;
    logic [COL_W-1:0] in_col_adv, out_col_adv, drain_addr;
    logic [ROW_W-1:0] in_row_adv, out_row_adv;
    logic [PW-1:0]    w_plus1;
    logic [2:0]       row_ok, col_ok;
    logic [7:0]       nb_mask;
    logic [3:0]       weight;
    logic             fe_in, fe_out, go, push_c, drain_ok;

    assign in_stall = cmd_full;
    assign go       = in_valid && !cmd_full;
    assign cmd_push = go && push_c;

    // Effective frame size after clamping.
    always_comb
    begin
        if (frame_width == '0)
        begin
            eff_w = CWE'(1);
        end
        else if (CMP_W'(frame_width) > CMP_W'(MAX_WIDTH))
        begin
            eff_w = CWE'(MAX_WIDTH);
        end
        else
        begin
            eff_w = CWE'(frame_width);
        end
        if (frame_height == '0)
        begin
            eff_h = RWE'(1);
        end
        else if (CMP_W'(frame_height) > CMP_W'(MAX_HEIGHT))
        begin
            eff_h = RWE'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = RWE'(frame_height);
        end
    end

    // Raster advance of both positions.
    always_comb
    begin
        in_col_inc  = {1'b0, in_col_reg} + CWE'(1);
        in_row_inc  = {1'b0, in_row_reg} + RWE'(1);
        out_col_inc = {1'b0, out_col_reg} + CWE'(1);
        out_row_inc = {1'b0, out_row_reg} + RWE'(1);
        oc_x        = {1'b0, out_col_reg};
        or_x        = {1'b0, out_row_reg};

        in_col_adv = in_col_inc[COL_W-1:0];
        in_row_adv = in_row_reg;
        if (in_col_inc >= eff_w)
        begin
            in_col_adv = '0;
            in_row_adv = (in_row_inc >= eff_h) ? '0 : in_row_inc[ROW_W-1:0];
        end
        out_col_adv = out_col_inc[COL_W-1:0];
        out_row_adv = out_row_reg;
        if (out_col_inc >= eff_w)
        begin
            out_col_adv = '0;
            out_row_adv = (out_row_inc >= eff_h) ? '0 : out_row_inc[ROW_W-1:0];
        end
        drain_addr = (out_col_inc >= eff_w) ? '0 : out_col_inc[COL_W-1:0];

        fe_in  = (in_col_inc == eff_w) && (in_row_inc == eff_h);
        fe_out = (out_col_inc == eff_w) && (out_row_inc == eff_h);
        w_plus1 = PW'(eff_w) + PW'(1);
    end

    // Neighbours of the output position that lie inside the frame.
    always_comb
    begin
        row_ok[0] = (out_row_reg != '0) && (or_x <= eff_h);
        row_ok[1] = (or_x < eff_h);
        row_ok[2] = (out_row_inc < eff_h);
        col_ok[0] = (out_col_reg != '0) && (oc_x <= eff_w);
        col_ok[1] = (oc_x < eff_w);
        col_ok[2] = (out_col_inc < eff_w);
        weight    = CENTRE_WT;
        for (int k = 0; k < 9; k++)
        begin
            if (k < 4)
            begin
                nb_mask[k] = row_ok[k / 3] && col_ok[k % 3];
            end
            else if (k > 4)
            begin
                nb_mask[k - 1] = row_ok[k / 3] && col_ok[k % 3];
            end
        end
        for (int k = 0; k < 8; k++)
        begin
            weight = weight + 4'(nb_mask[k]);
        end
    end

    // Classification of the request.
    always_comb
    begin
        drain_ok = aa_enable && (pending_reg != '0) &&
                   (in_col_reg == '0) && (in_row_reg == '0);
        push_c             = 1'b0;
        cmd_ctrl.is_pixel  = !action;
        cmd_ctrl.sepia     = sepia_enable;
        cmd_ctrl.emit      = EMIT_NONE;
        cmd_ctrl.frame_end = fe_out;
        cmd_ctrl.nb_mask   = nb_mask;
        cmd_ctrl.weight    = weight;
        cmd_addr           = in_col_reg;
        cmd_px             = {red_in, green_in, blue_in};
        cmd_col            = out_col_reg;
        cmd_row            = out_row_reg;
        in_col_next        = in_col_reg;
        in_row_next        = in_row_reg;
        out_col_next       = out_col_reg;
        out_row_next       = out_row_reg;
        pending_next       = pending_reg;
        if (!action)
        begin
            push_c      = 1'b1;
            in_col_next = in_col_adv;
            in_row_next = in_row_adv;
            if (aa_enable)
            begin
                if (pending_reg >= w_plus1)
                begin
                    cmd_ctrl.emit = EMIT_SMOOTH;
                    out_col_next  = out_col_adv;
                    out_row_next  = out_row_adv;
                    pending_next  = w_plus1;
                end
                else
                begin
                    pending_next = pending_reg + PW'(1);
                end
            end
            else
            begin
                cmd_ctrl.emit      = EMIT_DIRECT;
                cmd_ctrl.frame_end = fe_in;
                cmd_col            = in_col_reg;
                cmd_row            = in_row_reg;
                out_col_next       = in_col_adv;
                out_row_next       = in_row_adv;
                pending_next       = '0;
            end
        end
        else if (drain_ok)
        begin
            push_c        = 1'b1;
            cmd_ctrl.emit = EMIT_SMOOTH;
            cmd_addr      = drain_addr;
            cmd_px        = '0;
            out_col_next  = out_col_adv;
            out_row_next  = out_row_adv;
            pending_next  = pending_reg - PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
        end
        else if (go)
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ipf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipf_back
// Row stores, 3x3 window, weighted mean with serial divide, output register.
// ----------------------------------------------------------------------------
module ipf_back
    import ipf_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    output logic                               q_pop,
    input  wire ipf_ctrl_t                     q_ctrl,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
    input  wire logic [PX_W-1:0]               q_px,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]  q_col,
    input  wire logic [$clog2(MAX_HEIGHT)-1:0] q_row,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [$clog2(MAX_WIDTH)-1:0]       col_out,
    output logic [$clog2(MAX_HEIGHT)-1:0]      row_out,
    output logic [7:0]                         red_out,
    output logic [7:0]                         green_out,
    output logic [7:0]                         blue_out,
    output logic                               frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    ipf_ctrl_t        ctrl_reg;
    logic [COL_W-1:0] addr_reg, col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PX_W-1:0]  px_reg;
    logic [PX_W-1:0]  win_reg [9];
    logic [PX_W-1:0]  win_next [9];
    logic [3:0]       rem_reg [3];
    logic [3:0]       rem_next [3];
    logic [7:0]       num_reg [3];
    logic [7:0]       num_next [3];
    logic [2:0]       div_cnt_reg, div_cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       ch_out_reg [3];
    logic [7:0]       ch_out_next [3];
    logic [PX_W-1:0]  older_rdata, newer_rdata, shift_col [3];
    logic [11:0]      sum_c [3];
    logic [4:0]       trial [3];
    logic [8:0]       tint [3];
    logic             ram_we;

    ipf_ram #(.WIDTH(PX_W), .DEPTH(MAX_WIDTH)) u_older_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (newer_rdata),
        .raddr (q_addr),
        .rdata (older_rdata)
    );

    ipf_ram #(.WIDTH(PX_W), .DEPTH(MAX_WIDTH)) u_newer_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (px_reg),
        .raddr (q_addr),
        .rdata (newer_rdata)
    );

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign ram_we    = (state_reg == ST_LOAD) && ctrl_reg.is_pixel;
    assign out_valid = out_valid_reg;
    assign red_out   = ch_out_reg[0];
    assign green_out = ch_out_reg[1];
    assign blue_out  = ch_out_reg[2];

    always_comb
    begin
        shift_col[0] = older_rdata;
        shift_col[1] = newer_rdata;
        shift_col[2] = px_reg;
        tint[0] = {1'b0, px_reg[23:16]} + SEPIA_R_OFS;
        tint[1] = {1'b0, px_reg[15:8]} + SEPIA_G_OFS;
        tint[2] = {1'b0, px_reg[7:0]} + SEPIA_B_OFS;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_c[ch] = 12'({2'b0, win_reg[4][(2-ch)*8 +: 8], 2'b0}) +
                        12'(win_reg[4][(2-ch)*8 +: 8]);
            for (int k = 0; k < 9; k++)
            begin
                if (k < 4 && ctrl_reg.nb_mask[k])
                begin
                    sum_c[ch] = sum_c[ch] + 12'(win_reg[k][(2-ch)*8 +: 8]);
                end
                else if (k > 4 && ctrl_reg.nb_mask[k - 1])
                begin
                    sum_c[ch] = sum_c[ch] + 12'(win_reg[k][(2-ch)*8 +: 8]);
                end
            end
            trial[ch] = {rem_reg[ch], num_reg[ch][7]};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < 9; i++)
        begin
            win_next[i] = win_reg[i];
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            rem_next[ch]    = rem_reg[ch];
            num_next[ch]    = num_reg[ch];
            ch_out_next[ch] = ch_out_reg[ch];
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_next[r*3]     = win_reg[r*3 + 1];
                    win_next[r*3 + 1] = win_reg[r*3 + 2];
                    win_next[r*3 + 2] = shift_col[r];
                end
                if (ctrl_reg.emit == EMIT_SMOOTH)
                begin
                    state_next = ST_SUM;
                end
                else if (ctrl_reg.emit == EMIT_DIRECT)
                begin
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        ch_out_next[ch] = ctrl_reg.sepia ? tint[ch][8:1]
                                                         : px_reg[(2-ch)*8 +: 8];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    rem_next[ch] = sum_c[ch][11:8];
                    num_next[ch] = sum_c[ch][7:0];
                end
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                // One restoring step per cycle; quotient bits shift into num.
                for (int ch = 0; ch < 3; ch++)
                begin
                    if (trial[ch] >= {1'b0, ctrl_reg.weight})
                    begin
                        rem_next[ch] = 4'(trial[ch] - {1'b0, ctrl_reg.weight});
                        num_next[ch] = {num_reg[ch][6:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[ch] = trial[ch][3:0];
                        num_next[ch] = {num_reg[ch][6:0], 1'b0};
                    end
                end
                div_cnt_next = div_cnt_reg + 3'd1;
                if (div_cnt_reg == 3'd7)
                begin
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        ch_out_next[ch] = num_next[ch];
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ctrl_reg <= q_ctrl;
            addr_reg <= q_addr;
            px_reg   <= q_px;
            col_reg  <= q_col;
            row_reg  <= q_row;
        end
        if ((state_reg == ST_LOAD) && (ctrl_reg.emit != EMIT_NONE))
        begin
            col_out   <= col_reg;
            row_out   <= row_reg;
            frame_end <= ctrl_reg.frame_end;
        end
        div_cnt_reg <= div_cnt_next;
        for (int ch = 0; ch < 3; ch++)
        begin
            rem_reg[ch]    <= rem_next[ch];
            num_reg[ch]    <= num_next[ch];
            ch_out_reg[ch] <= ch_out_next[ch];
        end
    end

`ifndef ASSERT_OFF
    a_valid_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == ST_OUT))
        else $error("result shown outside the output state");

    a_sum_then_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |=> (state_reg == ST_DIV))
        else $error("divide did not follow the sum");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (ctrl_reg.weight >= 4'd5 && ctrl_reg.weight <= 4'd13))
        else $error("mean weight out of range");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> $past(q_pop))
        else $error("load without a popped request");
`endif

endmodule
`default_nettype wire

// ===== bench/image_post_filter_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_post_filter_core_tb
// Drives raster pixel streams through the post filter under several frame
// sizes and modes. A software copy of the filter predicts every pixel, and
// each emitted pixel is checked against it.
// ----------------------------------------------------------------------------

// One predicted output pixel, held until the block emits it.
typedef struct {
    logic [10:0] col;
    logic [11:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
} filtered_pixel_t;

// Software copy of the filter: line buffers, window, positions and registers.
class filter_scoreboard;
    bit [23:0]       older_line [2048];
    bit [23:0]       newer_line [2048];
    bit [23:0]       win [3][3];
    int unsigned     in_col, in_row, out_col, out_row, backlog;
    int unsigned     width_reg, height_reg;
    bit              smooth_on, sepia_on;
    filtered_pixel_t pixels_due [$];
    int              errors;

    function new();
        width_reg  = 640;
        height_reg = 480;
    endfunction

    function void set_reg(logic [1:0] idx, int unsigned value);
        case (idx)
            ipf_pkg::REG_WIDTH:  width_reg  = value & 12'hFFF;
            ipf_pkg::REG_HEIGHT: height_reg = value & 13'h1FFF;
            ipf_pkg::REG_AA:     smooth_on  = value[0];
            default:             sepia_on   = value[0];
        endcase
    endfunction

    function int unsigned eff_w();
        if (width_reg == 0) return 1;
        return (width_reg > 2048) ? 2048 : width_reg;
    endfunction

    function int unsigned eff_h();
        if (height_reg == 0) return 1;
        return (height_reg > 4096) ? 4096 : height_reg;
    endfunction

    function void step_pos(inout int unsigned c, inout int unsigned r);
        if (c + 1 >= eff_w()) begin
            c = 0;
            r = (r + 1 >= eff_h()) ? 0 : r + 1;
        end
        else
        begin
            c = c + 1;
        end
    endfunction

    function void shift_in(bit [23:0] up, bit [23:0] mid, bit [23:0] low);
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = low;
    endfunction

    function void queue_pixel(int unsigned c, int unsigned r, bit [23:0] px);
        filtered_pixel_t p;
        p.col   = c[10:0];
        p.row   = r[11:0];
        p.red   = px[23:16];
        p.green = px[15:8];
        p.blue  = px[7:0];
        p.last  = (c + 1 == eff_w()) && (r + 1 == eff_h());
        pixels_due.push_back(p);
    endfunction

    function bit [23:0] weighted_mean();
        int          rr, cc, wt;
        int unsigned sr, sg, sb, cnt;
        bit [23:0]   px;
        sr = 0; sg = 0; sb = 0; cnt = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                rr = int'(out_row) + dr;
                cc = int'(out_col) + dc;
                wt = (dr == 0 && dc == 0) ? 5 : 1;
                px = win[dr + 1][dc + 1];
                if (wt == 1 && (rr < 0 || rr >= int'(eff_h()) || cc < 0 ||
                                cc >= int'(eff_w())))
                    continue;
                sr += px[23:16] * wt;
                sg += px[15:8] * wt;
                sb += px[7:0] * wt;
                cnt += wt;
            end
        end
        return {8'(sr / cnt), 8'(sg / cnt), 8'(sb / cnt)};
    endfunction

    // Called for every request the block accepts.
    function void note_request(bit drain, bit [7:0] r, bit [7:0] g, bit [7:0] b);
        int unsigned w, c, pc;
        bit [23:0]   px, up, mid;
        w = eff_w();
        if (!drain) begin
            px  = {r, g, b};
            c   = in_col & 11'h7FF;
            up  = older_line[c];
            mid = newer_line[c];
            shift_in(up, mid, px);
            older_line[c] = mid;
            newer_line[c] = px;
            if (smooth_on) begin
                if (backlog >= w + 1) begin
                    queue_pixel(out_col, out_row, weighted_mean());
                    step_pos(out_col, out_row);
                    backlog = w + 1;
                end
                else
                begin
                    backlog++;
                end
                step_pos(in_col, in_row);
                return;
            end
            if (sepia_on)
                px = {8'((r + 9'd112) >> 1), 8'((g + 9'd66) >> 1), 8'((b + 9'd20) >> 1)};
            queue_pixel(in_col, in_row, px);
            step_pos(in_col, in_row);
            out_col = in_col;
            out_row = in_row;
            backlog = 0;
        end
        else if (smooth_on && backlog > 0 && in_col == 0 && in_row == 0) begin
            pc = (out_col + 1 >= w) ? 0 : out_col + 1;
            pc &= 11'h7FF;
            shift_in(older_line[pc], newer_line[pc], 24'd0);
            queue_pixel(out_col, out_row, weighted_mean());
            step_pos(out_col, out_row);
            backlog--;
        end
    endfunction

    // Called for every pixel the block emits.
    function void check_result(filtered_pixel_t got);
        filtered_pixel_t want;
        if (pixels_due.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected pixel col %0d row %0d rgb %h %h %h",
                         got.col, got.row, got.red, got.green, got.blue);
            return;
        end
        want = pixels_due.pop_front();
        if (got.col !== want.col || got.row !== want.row || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue ||
            got.last !== want.last) begin
            errors++;
            if (errors <= 10)
                $display("pixel mismatch: expected c%0d r%0d %h%h%h fe%0d, got c%0d r%0d %h%h%h fe%0d",
                         want.col, want.row, want.red, want.green, want.blue, want.last,
                         got.col, got.row, got.red, got.green, got.blue, got.last);
        end
    endfunction
endclass

module image_post_filter_core_tb;
    import ipf_pkg::*;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;
    localparam int   CYCLE_LIMIT = 4000000;
    // Cycles allowed for requests that yield nothing to clear the back end.
    localparam int   SETTLE_CYCLES = 200;

    typedef struct {
        bit       act;
        bit [7:0] r, g, b;
    } pixel_request_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_stall;
    logic        action;
    logic [7:0]  red_in, green_in, blue_in;
    logic        out_valid, out_stall;
    logic [10:0] col_out;
    logic [11:0] row_out;
    logic [7:0]  red_out, green_out, blue_out;
    logic        frame_end;

    filter_scoreboard sb;
    pixel_request_t   req_q [$];
    int               cycles;
    int               burst_left;
    int               gap_left;
    int               stall_mode;
    int               hold_cycles;
    bit               hold_req;
    bit               hold_done;
    int               rand_items;

    image_post_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .col_out   (col_out),
        .row_out   (row_out),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog: a hung block must not keep the run going forever.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("image_post_filter_core_tb failed");
            $finish;
        end
    end

    // Sender. Requests leave the queue in bursts of random length with random
    // gaps between them. A request is handed to the scoreboard at the edge
    // at which it is accepted, and a stalled request is held as it is.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                sb.note_request(action, red_in, green_in, blue_in);
                void'(req_q.pop_front());
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end
                else
                begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (burst_left > 0 && req_q.size() > 0) begin
                    action   <= req_q[0].act;
                    red_in   <= req_q[0].r;
                    green_in <= req_q[0].g;
                    blue_in  <= req_q[0].b;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            else if (!in_valid) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                end
                else if (req_q.size() > 0) begin
                    in_valid <= 1'b1;
                    action   <= req_q[0].act;
                    red_in   <= req_q[0].r;
                    green_in <= req_q[0].g;
                    blue_in  <= req_q[0].b;
                end
            end
        end
    end

    // Receiver. It stalls on its own changing pattern, and once, on request,
    // holds off for a long stretch so that the block fills and stalls its input.
    always @(posedge clk)
    begin
        filtered_pixel_t got;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got.col   = col_out;
                got.row   = row_out;
                got.red   = red_out;
                got.green = green_out;
                got.blue  = blue_out;
                got.last  = frame_end;
                sb.check_result(got);
            end
            if (cycles % 97 == 0)
                stall_mode <= $urandom_range(0, 3);
            if (hold_req && hold_cycles == 0) begin
                hold_cycles <= 600;
                hold_req    <= 1'b0;
                out_stall   <= 1'b1;
            end
            else if (hold_cycles > 1) begin
                hold_cycles <= hold_cycles - 1;
                out_stall   <= 1'b1;
            end
            else
            begin
                if (hold_cycles == 1)
                    hold_cycles <= 0;
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ((cycles % 8) < 3);
                endcase
            end
        end
    end

    task automatic add_request(bit act, bit [7:0] r, bit [7:0] g, bit [7:0] b);
        pixel_request_t q;
        q.act = act;
        q.r   = r;
        q.g   = g;
        q.b   = b;
        req_q.push_back(q);
    endtask

    // Mostly random channels, with the extremes now and then.
    function automatic bit [7:0] rand_chan();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Waits until every request is accepted and every pixel has come out,
    // then lets the back end finish any request that yields nothing.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (req_q.size() != 0 || in_valid || sb.pixels_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic set_mode(int unsigned w, int unsigned h, bit aa, bit sep);
        wait_idle();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_AA, aa);
        apb_write(REG_SEPIA, sep);
    endtask

    // One whole frame of random pixels, optionally followed by a full flush.
    task automatic add_frame(int unsigned w, int unsigned h, bit flush);
        for (int i = 0; i < w * h; i++)
            add_request(ACT_PIXEL, rand_chan(), rand_chan(), rand_chan());
        if (flush)
            for (int i = 0; i <= w; i++)
                add_request(ACT_DRAIN, rand_chan(), rand_chan(), rand_chan());
    endtask

    initial
    begin
        int unsigned w, h, n;
        bit          aa;
        sb          = new();
        cycles      = 0;
        burst_left  = 0;
        gap_left    = 0;
        stall_mode  = 0;
        hold_cycles = 0;
        hold_req    = 1'b0;
        hold_done   = 1'b0;
        rand_items  = 0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        action      = ACT_PIXEL;
        red_in      = '0;
        green_in    = '0;
        blue_in     = '0;
        out_stall   = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Fill both line buffers across the widest row used later, so that no
        // later width ever reads a line buffer entry that was never written.
        set_mode(40, 2, 1'b0, 1'b0);
        add_frame(40, 2, 1'b0);

        // Pass-through and sepia at the channel extremes.
        set_mode(3, 3, 1'b0, 1'b0);
        add_request(ACT_PIXEL, 8'h00, 8'h00, 8'h00);
        add_request(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        add_request(ACT_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        set_mode(3, 3, 1'b0, 1'b1);
        add_request(ACT_PIXEL, 8'h00, 8'h00, 8'h00);
        add_request(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        add_request(ACT_PIXEL, 8'h80, 8'h01, 8'hFE);

        // Smoothing with sepia also set: smoothing wins. A drain in mid-frame
        // is ignored; the drains at the end flush every pending pixel.
        set_mode(3, 3, 1'b1, 1'b1);
        for (int i = 0; i < 4; i++)
            add_request(ACT_PIXEL, 8'hFF, 8'h00, 8'hFF);
        add_request(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        for (int i = 0; i < 5; i++)
            add_request(ACT_PIXEL, 8'h00, 8'hFF, 8'h7F);
        for (int i = 0; i < 4; i++)
            add_request(ACT_DRAIN, 8'h00, 8'h00, 8'h00);

        // A zero size acts as one pixel, an oversized one as the maximum.
        set_mode(0, 0, 1'b1, 1'b0);
        add_request(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        add_request(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
        set_mode(4095, 8191, 1'b0, 1'b0);
        add_request(ACT_PIXEL, 8'h12, 8'h34, 8'h56);

        // Random phases, mostly small frames so that edges are hit often.
        while (rand_items < 800)
        begin
            w  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h  = $urandom_range(1, 5);
            aa = ($urandom_range(0, 9) < 6);
            set_mode(w, h, aa, $urandom_range(0, 1));
            n = $urandom_range(1, 3);
            for (int f = 0; f < n; f++)
            begin
                if ($urandom_range(0, 4) != 0) begin
                    // A well-formed frame: flushed, or pushed out by the next.
                    add_frame(w, h, aa && ($urandom_range(0, 2) != 0));
                    rand_items += w * h;
                end
                else
                begin
                    // Noise: loose pixels and stray drains.
                    for (int i = $urandom_range(1, 12); i > 0; i--)
                        add_request($urandom_range(0, 1), rand_chan(), rand_chan(),
                                    rand_chan());
                    rand_items += 6;
                end
            end
            if (rand_items > 300 && !hold_done) begin
                add_frame(w, h, aa);
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
        end

        wait_idle();
        if (sb.errors == 0)
            $display("image_post_filter_core_tb passed");
        else
            $display("image_post_filter_core_tb failed");
        $finish;
    end

endmodule
